[design/itk_pkg.sv]
// ----------------------------------------------------------------------------
// itk_pkg
// Shared types, constants and the key mapping for the touch key reader.
// ----------------------------------------------------------------------------
package itk_pkg;

  // Number of key channels served by the controller (8 to 16)
  localparam int unsigned Channels = 16;

  localparam logic [6:0] SlaveAddressReset = 7'd64;
  localparam int unsigned PaddrWidth = 3;
  localparam logic [0:0] RegSlaveAddress = 1'b0;

  localparam logic [7:0] KeyNone  = 8'hFF;
  localparam logic [7:0] KeyM     = 8'd77;
  localparam logic [7:0] KeyHash  = 8'd35;
  localparam logic [4:0] PosZero  = 5'd11;
  localparam logic [4:0] PosM     = 5'd10;
  localparam logic [4:0] PosHash  = 5'd12;
  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [4:0] ChanFull = 5'd16;
  localparam logic [4:0] ChanLimit = 5'(Channels);
  localparam logic [4:0] FirstByteEnd = 5'd8;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START2   = 5'd1,
    PH_ADR_LO   = 5'd2,
    PH_ADR_HI   = 5'd3,
    PH_AACK_LO  = 5'd4,
    PH_AACK_HI  = 5'd5,
    PH_DAT_LO   = 5'd6,
    PH_DAT_HI   = 5'd7,
    PH_MACK_LO  = 5'd8,
    PH_MACK_HI  = 5'd9,
    PH_STOP_LO  = 5'd10,
    PH_STOP_HI  = 5'd11,
    PH_STOP_END = 5'd12
  } itk_phase_t;

  typedef struct packed {
    logic       start_request;
    logic       sda_sample;
  } itk_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] key_code;
    logic       address_nack;
  } itk_result_t;

  function automatic logic [7:0] map_key(input logic [4:0] pos);
    logic [7:0] code;
    begin
      if (pos inside {[5'd1:5'd9]}) code = {3'b000, pos};
      else if (pos == PosZero)      code = 8'd0;
      else if (pos == PosM)         code = KeyM;
      else if (pos == PosHash)      code = KeyHash;
      else                          code = KeyNone;
      return code;
    end
  endfunction

endpackage

[design/itk_cfg.sv]
// ----------------------------------------------------------------------------
// itk_cfg
// APB register file holding the slave address of the key controller.
// ----------------------------------------------------------------------------
module itk_cfg import itk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [6:0]            slave_address
);

  logic reg_hit;

  // word index is paddr[2]; only register 0 exists
  assign reg_hit = (paddr[2] == RegSlaveAddress);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SlaveAddressReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      slave_address <= pwdata[6:0];
    end
  end

  assign prdata = reg_hit ? {25'd0, slave_address} : 32'd0;

endmodule

[design/itk_engine.sv]
// ----------------------------------------------------------------------------
// itk_engine
// Bus phase sequencer: advances one phase per enabled tick and forms the
// line levels and status for that tick.
// ----------------------------------------------------------------------------
module itk_engine import itk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  itk_item_t   item,
  input  logic [6:0]  slave_address,
  output itk_result_t result
);

  itk_phase_t bus_phase, bus_phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] address_shift, address_shift_next;
  logic [4:0] key_position, key_position_next;
  logic [4:0] channel_index, channel_index_next;
  logic       nack_flag, nack_flag_next;

  logic [3:0] bit_inc;
  logic [4:0] chan_inc;
  logic       second_byte;

  assign bit_inc     = bit_count + 4'd1;
  assign chan_inc    = (channel_index < ChanFull) ? channel_index + 5'd1 : channel_index;
  assign second_byte = (key_position == 5'd0) && (channel_index == FirstByteEnd) &&
                       (Channels > 8);

  // next state
  always_comb begin
    bus_phase_next     = bus_phase;
    bit_count_next     = bit_count;
    address_shift_next = address_shift;
    key_position_next  = key_position;
    channel_index_next = channel_index;
    nack_flag_next     = nack_flag;
    case (bus_phase)
      PH_IDLE: begin
        if (item.start_request) begin
          address_shift_next = {slave_address, 1'b1};
          bit_count_next     = 4'd0;
          key_position_next  = 5'd0;
          channel_index_next = 5'd0;
          nack_flag_next     = 1'b0;
          bus_phase_next     = PH_START2;
        end
      end
      PH_START2:  bus_phase_next = PH_ADR_LO;
      PH_ADR_LO:  bus_phase_next = PH_ADR_HI;
      PH_ADR_HI: begin
        address_shift_next = {address_shift[6:0], 1'b0};
        if (bit_inc >= BitsPerByte) begin
          bit_count_next = 4'd0;
          bus_phase_next = PH_AACK_LO;
        end else begin
          bit_count_next = bit_inc;
          bus_phase_next = PH_ADR_LO;
        end
      end
      PH_AACK_LO: bus_phase_next = PH_AACK_HI;
      PH_AACK_HI: begin
        if (item.sda_sample) begin
          nack_flag_next = 1'b1;
          bus_phase_next = PH_STOP_LO;
        end else begin
          bus_phase_next = PH_DAT_LO;
        end
      end
      PH_DAT_LO:  bus_phase_next = PH_DAT_HI;
      PH_DAT_HI: begin
        channel_index_next = chan_inc;
        if (key_position == 5'd0 && item.sda_sample && chan_inc <= ChanLimit) begin
          key_position_next = chan_inc;
        end
        if (bit_inc >= BitsPerByte) begin
          bit_count_next = 4'd0;
          bus_phase_next = PH_MACK_LO;
        end else begin
          bit_count_next = bit_inc;
          bus_phase_next = PH_DAT_LO;
        end
      end
      PH_MACK_LO: bus_phase_next = PH_MACK_HI;
      PH_MACK_HI: bus_phase_next = second_byte ? PH_DAT_LO : PH_STOP_LO;
      PH_STOP_LO: bus_phase_next = PH_STOP_HI;
      PH_STOP_HI: bus_phase_next = PH_STOP_END;
      PH_STOP_END: bus_phase_next = PH_IDLE;
      default:    bus_phase_next = PH_IDLE;
    endcase
  end

  // outputs for this tick
  always_comb begin
    result.scl_level    = 1'b1;
    result.sda_release  = 1'b1;
    result.busy_res     = 1'b1;
    result.done_res     = 1'b0;
    result.key_code     = KeyNone;
    result.address_nack = 1'b0;
    case (bus_phase)
      PH_IDLE: begin
        if (item.start_request) result.sda_release = 1'b0;
        else                    result.busy_res    = 1'b0;
      end
      PH_START2: begin
        result.scl_level   = 1'b0;
        result.sda_release = 1'b0;
      end
      PH_ADR_LO: begin
        result.scl_level   = 1'b0;
        result.sda_release = address_shift[7];
      end
      PH_ADR_HI:  result.sda_release = address_shift[7];
      PH_AACK_LO: result.scl_level = 1'b0;
      PH_AACK_HI: ;
      PH_DAT_LO:  result.scl_level = 1'b0;
      PH_DAT_HI:  ;
      PH_MACK_LO: begin
        result.scl_level   = 1'b0;
        result.sda_release = !second_byte;
      end
      PH_MACK_HI: result.sda_release = !second_byte;
      PH_STOP_LO: begin
        result.scl_level   = 1'b0;
        result.sda_release = 1'b0;
      end
      PH_STOP_HI: result.sda_release = 1'b0;
      PH_STOP_END: begin
        result.done_res     = 1'b1;
        result.address_nack = nack_flag;
        result.key_code     = nack_flag ? KeyNone : map_key(key_position);
      end
      default:    result.busy_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase     <= PH_IDLE;
      bit_count     <= 4'd0;
      address_shift <= 8'd0;
      key_position  <= 5'd0;
      channel_index <= 5'd0;
      nack_flag     <= 1'b0;
    end else if (step) begin
      bus_phase     <= bus_phase_next;
      bit_count     <= bit_count_next;
      address_shift <= address_shift_next;
      key_position  <= key_position_next;
      channel_index <= channel_index_next;
      nack_flag     <= nack_flag_next;
    end
  end

endmodule

[design/i2c_touch_key_reader_top.sv]
// ----------------------------------------------------------------------------
// i2c_touch_key_reader_top
// Two-wire bus master that reads a touch key controller, one bus phase tick
// per stream item, and returns line levels, status and the mapped key.
// ----------------------------------------------------------------------------
// Path: an accepted tick passes the input register, then the phase sequencer
// into the result register.
// Throughput: one tick per cycle unless the sink stalls the result register.
// Reset: synchronous, active high; the sequencer returns to idle, both
// registers empty and the slave address goes back to 64.
// ----------------------------------------------------------------------------
module i2c_touch_key_reader_top import itk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // tick stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] start_request, [1] sda_sample
  // result stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [0] scl_level, [1] sda_release,
                                           // [2] busy_res, [10:3] key_code,
                                           // [11] address_nack
  output logic                  m_tlast,   // done_res: STOP tick of a read
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        in_valid;
  itk_item_t   in_item;
  logic        advance;
  logic        step;
  logic [6:0]  slave_address;
  itk_result_t step_result;
  itk_result_t out_result;

  // Advance when the result register is free or being emptied this cycle
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  // Take a new tick whenever the input register empties or is empty
  assign s_tready = !in_valid || advance;

  itk_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .slave_address (slave_address)
  );

  // Input register: hold the tick until the sequencer consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.start_request <= s_tdata[0];
      in_item.sda_sample    <= s_tdata[1];
    end
  end

  // Phase sequencer: state moves on only when a tick is processed
  itk_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (in_item),
    .slave_address (slave_address),
    .result        (step_result)
  );

  // Result register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {4'd0, out_result.address_nack, out_result.key_code,
                    out_result.busy_res, out_result.sda_release,
                    out_result.scl_level};
  assign m_tlast = out_result.done_res;

endmodule

[bench/tb_i2c_touch_key_reader_top.sv]
// ----------------------------------------------------------------------------
// tb_i2c_touch_key_reader_top
// Self-checking bench for the touch key reader. Bus phase ticks are streamed
// in, each accepted tick is run through a local model of the phase sequencer,
// and every returned item is compared field by field with the oldest
// prediction. Stimulus is mostly well-formed key reads with random content,
// mixed with noise, with random gaps on both stream sides in most runs.
// ----------------------------------------------------------------------------
module tb_i2c_touch_key_reader_top;
  import itk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Extra wait after every prediction is met, as slack for the pipe to settle
  localparam int unsigned SettleCycles = 4;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [0] start_request, [1] sda_sample
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;   // [0] scl_level, [1] sda_release,
                                    // [2] busy_res, [10:3] key_code,
                                    // [11] address_nack
  logic                  m_tlast;   // done_res
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  i2c_touch_key_reader_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Bus levels and status predicted for each accepted tick, oldest first
  itk_result_t pending_bus_levels[$];
  int unsigned error_count;
  int unsigned ticks_sent;
  bit          gaps_on;
  bit          stalls_on;

  // Local copy of the sequencer state and the address register
  itk_phase_t  seq_phase;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [4:0]  seq_key_pos;
  logic [4:0]  seq_chan;
  bit          seq_nack;
  logic [6:0]  seq_slave_addr;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Advance the local sequencer by one tick and return the expected item
  function automatic itk_result_t bus_tick(input bit req, input bit sda);
    itk_result_t r;
    bit          more;
    more = (seq_key_pos == 5'd0) && (seq_chan == FirstByteEnd) && (Channels > 8);
    r.scl_level    = 1'b1;
    r.sda_release  = 1'b1;
    r.busy_res     = 1'b1;
    r.done_res     = 1'b0;
    r.key_code     = KeyNone;
    r.address_nack = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (req) begin
          r.sda_release = 1'b0;
          seq_shift     = {seq_slave_addr, 1'b1};
          seq_bits      = 4'd0;
          seq_key_pos   = 5'd0;
          seq_chan      = 5'd0;
          seq_nack      = 1'b0;
          seq_phase     = PH_START2;
        end else begin
          r.busy_res = 1'b0;
        end
      end
      PH_START2: begin
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
        seq_phase     = PH_ADR_LO;
      end
      PH_ADR_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = seq_shift[7];
        seq_phase     = PH_ADR_HI;
      end
      PH_ADR_HI: begin
        r.sda_release = seq_shift[7];
        seq_shift     = seq_shift << 1;
        seq_bits      = seq_bits + 4'd1;
        if (seq_bits >= BitsPerByte) begin
          seq_bits  = 4'd0;
          seq_phase = PH_AACK_LO;
        end else begin
          seq_phase = PH_ADR_LO;
        end
      end
      PH_AACK_LO: begin
        r.scl_level = 1'b0;
        seq_phase   = PH_AACK_HI;
      end
      PH_AACK_HI: begin
        if (sda) begin
          seq_nack  = 1'b1;
          seq_phase = PH_STOP_LO;
        end else begin
          seq_phase = PH_DAT_LO;
        end
      end
      PH_DAT_LO: begin
        r.scl_level = 1'b0;
        seq_phase   = PH_DAT_HI;
      end
      PH_DAT_HI: begin
        if (seq_chan < ChanFull) seq_chan = seq_chan + 5'd1;
        // Keep only the first high bit, and only within the channel count
        if (seq_key_pos == 5'd0 && sda && seq_chan <= Channels) seq_key_pos = seq_chan;
        seq_bits = seq_bits + 4'd1;
        if (seq_bits >= BitsPerByte) begin
          seq_bits  = 4'd0;
          seq_phase = PH_MACK_LO;
        end else begin
          seq_phase = PH_DAT_LO;
        end
      end
      PH_MACK_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = !more;
        seq_phase     = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        // ACK asks for the second byte, NACK closes the read
        if (more) begin
          r.sda_release = 1'b0;
          seq_phase     = PH_DAT_LO;
        end else begin
          seq_phase = PH_STOP_LO;
        end
      end
      PH_STOP_LO: begin
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
        seq_phase     = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        r.sda_release = 1'b0;
        seq_phase     = PH_STOP_END;
      end
      PH_STOP_END: begin
        r.done_res     = 1'b1;
        r.address_nack = seq_nack;
        if (seq_nack) begin
          r.key_code = KeyNone;
        end else if (seq_key_pos >= 5'd1 && seq_key_pos <= 5'd9) begin
          r.key_code = {3'b000, seq_key_pos};
        end else begin
          case (seq_key_pos)
            PosZero: r.key_code = 8'd0;
            PosM:    r.key_code = KeyM;
            PosHash: r.key_code = KeyHash;
            default: r.key_code = KeyNone;
          endcase
        end
        seq_phase = PH_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        seq_phase  = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Offer one tick after a random gap, hold until taken, then predict it.
  // tvalid stays high afterwards: the caller sends again or drains at once.
  task automatic send_tick(input bit req, input bit sda);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b000000, sda, req};
    do @(posedge clk); while (!s_tready);
    pending_bus_levels.push_back(bus_tick(req, sda));
    ticks_sent++;
  endtask

  // One tick of a read in progress: the SDA level is what a slave would
  // present at the sampling phases, random elsewhere
  task automatic next_tick(input bit addr_nack, input int unsigned key_at, input bit hold_req);
    bit          sda;
    int unsigned pos;
    pos = seq_chan + 1;
    sda = 1'($urandom_range(0, 1));
    if (seq_phase == PH_AACK_HI) begin
      sda = addr_nack;
    end else if (seq_phase == PH_DAT_HI) begin
      if (pos == key_at) sda = 1'b1;
      else if (key_at == 0 || pos < key_at) sda = 1'b0;
    end
    send_tick(hold_req ? 1'b1 : 1'($urandom_range(0, 1)), sda);
  endtask

  // Start a read if idle, then run it through to the STOP tick
  task automatic run_read(input bit addr_nack, input int unsigned key_at, input bit hold_req);
    if (seq_phase == PH_IDLE) send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (seq_phase != PH_IDLE) next_tick(addr_nack, key_at, hold_req);
  endtask

  // Drop tvalid, wait for every prediction to be met, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bus_levels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_slave_address(input logic [6:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {RegSlaveAddress, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {25'd0, want}) report("slave_address readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_slave_address(input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegSlaveAddress, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seq_slave_addr = value;
    check_slave_address(value);
  endtask

  // Ticks with no request leave the bus released; SDA is ignored
  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
  endtask

  // Key in the first byte: NACK straight after it; requests held high
  // throughout the second read must be ignored while busy
  task automatic test_first_byte_key();
    run_read(1'b0, 1, 1'b0);
    run_read(1'b0, 8, 1'b1);
    drain();
  endtask

  // Empty first byte: ACK and read on; also the no-key case
  task automatic test_second_byte();
    run_read(1'b0, 10, 1'b0);
    run_read(1'b0, 0, 1'b1);
    drain();
  endtask

  task automatic test_address_nack();
    run_read(1'b1, 3, 1'b1);
    drain();
  endtask

  // Address is latched at START: a write in mid-read applies to the next one
  task automatic test_address_latch();
    send_tick(1'b1, 1'b0);
    repeat (9) next_tick(1'b0, 12, 1'b0);
    drain();
    write_slave_address(7'h2A);
    run_read(1'b0, 12, 1'b0);
    run_read(1'b0, 11, 1'b0);
    drain();
  endtask

  // Mostly well-formed reads with random key position and rare address
  // NACKs, mixed with bursts of raw random ticks
  task automatic test_random(input int unsigned count, input logic [6:0] addr, input bit idling);
    int unsigned stop_at;
    gaps_on   = idling;
    stalls_on = idling;
    write_slave_address(addr);
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        run_read($urandom_range(0, 7) == 0, $urandom_range(0, 16), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    drain();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Receiver: hold tready low for a random count before each item
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = stalls_on ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Compare every accepted item with the oldest prediction
  always @(posedge clk) begin
    itk_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bus_levels.size() == 0) begin
        report("unexpected item", m_tdata, 0);
      end else begin
        want = pending_bus_levels.pop_front();
        if (m_tdata[0] !== want.scl_level)     report("scl_level", m_tdata[0], want.scl_level);
        if (m_tdata[1] !== want.sda_release)   report("sda_release", m_tdata[1], want.sda_release);
        if (m_tdata[2] !== want.busy_res)      report("busy_res", m_tdata[2], want.busy_res);
        if (m_tlast !== want.done_res)         report("done_res", m_tlast, want.done_res);
        if (m_tdata[10:3] !== want.key_code)   report("key_code", m_tdata[10:3], want.key_code);
        if (m_tdata[11] !== want.address_nack) report("address_nack", m_tdata[11], want.address_nack);
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = 32'd0;
    error_count = 0;
    ticks_sent  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    seq_phase      = PH_IDLE;
    seq_bits       = 4'd0;
    seq_shift      = 8'd0;
    seq_key_pos    = 5'd0;
    seq_chan       = 5'd0;
    seq_nack       = 1'b0;
    seq_slave_addr = SlaveAddressReset;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_slave_address(SlaveAddressReset);
    test_idle_ticks();
    test_first_byte_key();
    test_second_byte();
    test_address_nack();
    test_address_latch();
    test_random(60, 7'd0, 1'b1);
    test_random(60, 7'h7F, 1'b1);
    test_random(50, 7'($urandom_range(0, 127)), 1'b0);
    test_random(60, 7'($urandom_range(0, 127)), 1'b1);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
